@@ design/gst_pkg.sv @@
// Package for the gamepad state table: event/result word types, operation codes,
// direction bits and the button-to-mask table. No dependencies.
package gst_pkg;

  // Operation codes of an event word; codes 6 and 7 are undefined
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_BTN_DOWN = 3'd2,
    OP_BTN_UP   = 3'd3,
    OP_AXIS     = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  // Axis numbers that drive direction bits
  localparam logic [7:0] AXIS_HORIZONTAL = 8'd0;
  localparam logic [7:0] AXIS_VERTICAL   = 8'd1;

  // Direction bits of the button mask
  localparam logic [15:0] BIT_UP    = 16'h0001;
  localparam logic [15:0] BIT_DOWN  = 16'h0002;
  localparam logic [15:0] BIT_LEFT  = 16'h0004;
  localparam logic [15:0] BIT_RIGHT = 16'h0008;

  localparam logic [14:0] AXIS_THRESHOLD_RESET = 15'd20000;

  // Number of standard controller buttons
  localparam int NUM_BUTTONS = 15;

  // Mask bit for each standard button; guide maps to nothing
  localparam logic [15:0] BUTTON_BITS [NUM_BUTTONS] = '{
    16'h0010, 16'h0020, 16'h0040, 16'h0080, 16'h0100, 16'h0000, 16'h0200,
    16'h1000, 16'h2000, 16'h0400, 16'h0800,
    BIT_UP, BIT_DOWN, BIT_LEFT, BIT_RIGHT
  };

  // One input event word
  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        device_id;
    logic [7:0]         button_code;
    logic [7:0]         axis_number;
    logic signed [15:0] axis_value;
    logic [2:0]         pad_number;
  } gst_event_t;

  // One result word
  typedef struct packed {
    logic [15:0] pad_buttons;
    logic [3:0]  pads_connected;
    logic        id_not_found;
  } gst_result_t;

  // Map a button code to its mask bit; unknown codes map to none
  function automatic logic [15:0] map_button(input logic [7:0] code);
    logic [15:0] bits;
    bits = 16'h0000;
    if (code < 8'(NUM_BUTTONS)) begin
      bits = BUTTON_BITS[code[3:0]];
    end
    return bits;
  endfunction

endpackage

@@ design/gst_slot_table.sv @@
// Slot table of the gamepad state table: ids, button masks and occupancy count,
// updated by one event word per cycle while fire is high. Depends on gst_pkg.
module gst_slot_table #(
  parameter int MAX_PADS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  gst_pkg::gst_event_t   ev,
  input  logic [14:0]           threshold,
  output gst_pkg::gst_result_t  res
);
  import gst_pkg::*;

  localparam int CW = $clog2(MAX_PADS + 1);

  logic [31:0]   ids_r     [MAX_PADS];
  logic [31:0]   ids_nxt   [MAX_PADS];
  logic [15:0]   masks_r   [MAX_PADS];
  logic [15:0]   masks_nxt [MAX_PADS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  op_t                 op;
  logic [MAX_PADS-1:0] hit;
  logic [MAX_PADS-1:0] first_hit;
  logic [MAX_PADS-1:0] shift_sel;
  logic [MAX_PADS-1:0] add_sel;
  logic                found;
  logic                full;
  logic                do_add;
  logic                do_remove;
  logic                do_modify;
  logic [15:0]         set_bits;
  logic [15:0]         clr_bits;
  logic [15:0]         neg_bit;
  logic [15:0]         pos_bit;
  logic signed [16:0]  v_ext;
  logic signed [16:0]  t_pos;
  logic signed [16:0]  t_neg;
  logic [15:0]         rd_mask;

  assign op = op_t'(ev.operation);

  // Match the id against occupied slots and in-range slot selects
  always_comb begin
    for (int i = 0; i < MAX_PADS; i++) begin
      hit[i]     = (5'(i) < 5'(count_r)) && (ids_r[i] == ev.device_id);
      add_sel[i] = (5'(i) == 5'(count_r));
    end
  end

  // Keep the lowest match; every slot at or above it shifts on removal
  assign first_hit = hit & (~hit + 1'b1);
  assign shift_sel = ~(first_hit - 1'b1);
  assign found     = |hit;
  assign full      = (5'(count_r) >= 5'(MAX_PADS));

  assign do_add    = fire && (op == OP_ADD) && !full;
  assign do_remove = fire && (op == OP_REMOVE) && found;
  assign do_modify = fire && (op == OP_BTN_DOWN || op == OP_BTN_UP || op == OP_AXIS);

  // Axis thresholds in 17-bit signed range
  assign v_ext = $signed({ev.axis_value[15], ev.axis_value});
  assign t_pos = $signed({2'b00, threshold});
  assign t_neg = -t_pos;

  // Build the bits to set and clear on the matched slot
  always_comb begin
    set_bits = 16'h0000;
    clr_bits = 16'h0000;
    neg_bit  = 16'h0000;
    pos_bit  = 16'h0000;
    if (ev.axis_number == AXIS_HORIZONTAL) begin
      neg_bit = BIT_LEFT;
      pos_bit = BIT_RIGHT;
    end else if (ev.axis_number == AXIS_VERTICAL) begin
      neg_bit = BIT_UP;
      pos_bit = BIT_DOWN;
    end
    case (op)
      OP_BTN_DOWN: begin
        set_bits = map_button(ev.button_code);
      end
      OP_BTN_UP: begin
        clr_bits = map_button(ev.button_code);
      end
      OP_AXIS: begin
        clr_bits = neg_bit | pos_bit;
        set_bits = ((v_ext < t_neg) ? neg_bit : 16'h0000) |
                   ((v_ext > t_pos) ? pos_bit : 16'h0000);
      end
      default: begin
        set_bits = 16'h0000;
        clr_bits = 16'h0000;
      end
    endcase
  end

  // Next value of each slot: add, shift down on removal, or modify in place
  for (genvar g = 0; g < MAX_PADS; g++) begin : gen_slot
    logic [31:0] up_id;
    logic [15:0] up_mask;
    if (g + 1 < MAX_PADS) begin : gen_above
      assign up_id   = ids_r[g+1];
      assign up_mask = masks_r[g+1];
    end else begin : gen_top
      assign up_id   = ids_r[g];
      assign up_mask = 16'h0000;
    end
    assign ids_nxt[g] = (do_add && add_sel[g])      ? ev.device_id :
                        (do_remove && shift_sel[g]) ? up_id : ids_r[g];
    assign masks_nxt[g] = (do_add && add_sel[g])      ? 16'h0000 :
                          (do_remove && shift_sel[g]) ? up_mask :
                          (do_modify && first_hit[g]) ?
                            ((masks_r[g] & ~clr_bits) | set_bits) : masks_r[g];
  end

  assign count_nxt = do_add    ? count_r + 1'b1 :
                     do_remove ? count_r - 1'b1 : count_r;

  // Read the requested slot; unused slots read as zero
  always_comb begin
    rd_mask = 16'h0000;
    for (int i = 0; i < MAX_PADS; i++) begin
      if ((5'(i) == 5'(ev.pad_number)) && (5'(i) < 5'(count_r))) begin
        rd_mask = masks_r[i];
      end
    end
  end

  // Assemble the result word
  always_comb begin
    res.pad_buttons    = (op == OP_READ) ? rd_mask : 16'h0000;
    res.pads_connected = 4'(count_nxt);
    case (op)
      OP_ADD:      res.id_not_found = full;
      OP_REMOVE,
      OP_BTN_DOWN,
      OP_BTN_UP,
      OP_AXIS:     res.id_not_found = !found;
      default:     res.id_not_found = 1'b0;
    endcase
  end

  // Hold masks and count; clear them on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < MAX_PADS; i++) begin
        masks_r[i] <= 16'h0000;
      end
    end else if (fire) begin
      count_r <= count_nxt;
      for (int i = 0; i < MAX_PADS; i++) begin
        masks_r[i] <= masks_nxt[i];
      end
    end
  end

  // Hold ids; entries are only read once written
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MAX_PADS; i++) begin
        ids_r[i] <= ids_nxt[i];
      end
    end
  end

endmodule

@@ design/gamepad_state_table_unit.sv @@
// Gamepad state table: one event word in, one result word out per event.
// An accepted word is held in the input register and processed into the result
// register once that is free; its result is offered from then on. One word per
// cycle while out_stall is low, set by the single-pass slot table update between them.
// Reset: table empty, masks zero, axis threshold 20000; ids are unknown until added.
module gamepad_state_table_unit #(
  parameter int MAX_PADS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_device_id,
  input  logic [7:0]  in_button_code,
  input  logic [7:0]  in_axis_number,
  input  logic signed [15:0] in_axis_value,
  input  logic [2:0]  in_pad_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pad_buttons,
  output logic [3:0]  out_pads_connected,
  output logic        out_id_not_found
);
  import gst_pkg::*;

  logic [14:0]  threshold_r;
  gst_event_t   ev_r;
  logic         ev_valid_r;
  logic         ev_valid_nxt;
  gst_result_t  res;
  gst_result_t  res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         fire;
  logic         in_take;

  // Process the held word when the result register is free
  assign fire     = ev_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = ev_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  assign ev_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : ev_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  gst_slot_table #(
    .MAX_PADS (MAX_PADS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .ev        (ev_r),
    .threshold (threshold_r),
    .res       (res)
  );

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= AXIS_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_r.operation   <= in_operation;
      ev_r.device_id   <= in_device_id;
      ev_r.button_code <= in_button_code;
      ev_r.axis_number <= in_axis_number;
      ev_r.axis_value  <= in_axis_value;
      ev_r.pad_number  <= in_pad_number;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pad_buttons    = res_r.pad_buttons;
  assign out_pads_connected = res_r.pads_connected;
  assign out_id_not_found   = res_r.id_not_found;

endmodule

@@ tb/gamepad_state_table_unit_tb.sv @@
// Self-checking testbench for gamepad_state_table_unit: drives event words, tracks
// the pad table in a local model and checks every result word field by field.
// Depends on gst_pkg (operation codes, direction bits, event/result word types).
module gamepad_state_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gst_pkg::*;

  localparam int PADS          = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 5;

  // Operation codes the block leaves undefined
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  // Ids used by the directed tests
  localparam logic [31:0] ID_FIRST    = 32'h0000_0000;
  localparam logic [31:0] ID_SECOND   = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_STRANGER = 32'h1234_5678;

  localparam logic [7:0] CODE_UNKNOWN = 8'hFF;
  localparam logic [7:0] AXIS_UNUSED  = 8'hFF;

  // Standard controller button numbers
  typedef enum logic [7:0] {
    BTN_A = 8'd0, BTN_B, BTN_X, BTN_Y, BTN_BACK, BTN_GUIDE, BTN_START,
    BTN_LEFT_STICK, BTN_RIGHT_STICK, BTN_LEFT_SHOULDER, BTN_RIGHT_SHOULDER,
    BTN_DPAD_UP, BTN_DPAD_DOWN, BTN_DPAD_LEFT, BTN_DPAD_RIGHT
  } button_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_operation;
  logic [31:0] in_device_id;
  logic [7:0]  in_button_code;
  logic [7:0]  in_axis_number;
  logic signed [15:0] in_axis_value;
  logic [2:0]  in_pad_number;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_pad_buttons;
  logic [3:0]  out_pads_connected;
  logic        out_id_not_found;

  // Local copy of the pad table and the threshold register
  logic [31:0] pad_id [PADS] = '{default: '0};
  logic [15:0] pad_mask [PADS] = '{default: '0};
  int          pad_count = 0;
  logic [14:0] threshold_now = AXIS_THRESHOLD_RESET;

  gst_result_t pending_status[$];
  int          events_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  bit          holding = 1'b0;

  gamepad_state_table_unit #(.MAX_PADS(PADS)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_device_id       (in_device_id),
    .in_button_code     (in_button_code),
    .in_axis_number     (in_axis_number),
    .in_axis_value      (in_axis_value),
    .in_pad_number      (in_pad_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pad_buttons    (out_pad_buttons),
    .out_pads_connected (out_pads_connected),
    .out_id_not_found   (out_id_not_found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mask bit that a button press sets; guide and unknown codes set none
  function automatic logic [15:0] button_bit(input logic [7:0] code);
    case (code)
      BTN_A:              return 16'h0010;
      BTN_B:              return 16'h0020;
      BTN_X:              return 16'h0040;
      BTN_Y:              return 16'h0080;
      BTN_BACK:           return 16'h0100;
      BTN_GUIDE:          return 16'h0000;
      BTN_START:          return 16'h0200;
      BTN_LEFT_STICK:     return 16'h1000;
      BTN_RIGHT_STICK:    return 16'h2000;
      BTN_LEFT_SHOULDER:  return 16'h0400;
      BTN_RIGHT_SHOULDER: return 16'h0800;
      BTN_DPAD_UP:        return BIT_UP;
      BTN_DPAD_DOWN:      return BIT_DOWN;
      BTN_DPAD_LEFT:      return BIT_LEFT;
      BTN_DPAD_RIGHT:     return BIT_RIGHT;
      default:            return 16'h0000;
    endcase
  endfunction

  // Apply one event to the local table and return the result word it owes
  function automatic gst_result_t apply_event_to_table(input gst_event_t ev);
    gst_result_t r;
    int          hit;
    int          v;
    int          t;
    logic [15:0] m;
    r = '0;
    hit = -1;
    for (int i = 0; i < pad_count; i++) begin
      if (hit < 0 && pad_id[i] == ev.device_id) hit = i;
    end
    v = int'($signed(ev.axis_value));
    t = int'(threshold_now);
    case (ev.operation)
      OP_ADD: begin
        if (pad_count >= PADS) begin
          r.id_not_found = 1'b1;
        end else begin
          pad_id[pad_count] = ev.device_id;
          pad_mask[pad_count] = '0;
          pad_count++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          r.id_not_found = 1'b1;
        end else begin
          // shift later slots down, ids with masks
          for (int i = hit; i < pad_count - 1; i++) begin
            pad_id[i] = pad_id[i + 1];
            pad_mask[i] = pad_mask[i + 1];
          end
          pad_count--;
          pad_mask[pad_count] = '0;
        end
      end
      OP_BTN_DOWN: begin
        if (hit < 0) r.id_not_found = 1'b1;
        else pad_mask[hit] = pad_mask[hit] | button_bit(ev.button_code);
      end
      OP_BTN_UP: begin
        if (hit < 0) r.id_not_found = 1'b1;
        else pad_mask[hit] = pad_mask[hit] & ~button_bit(ev.button_code);
      end
      OP_AXIS: begin
        if (hit < 0) begin
          r.id_not_found = 1'b1;
        end else begin
          m = pad_mask[hit];
          if (ev.axis_number == AXIS_HORIZONTAL) begin
            m = (v < -t) ? (m | BIT_LEFT) : (m & ~BIT_LEFT);
            m = (v > t) ? (m | BIT_RIGHT) : (m & ~BIT_RIGHT);
          end else if (ev.axis_number == AXIS_VERTICAL) begin
            m = (v < -t) ? (m | BIT_UP) : (m & ~BIT_UP);
            m = (v > t) ? (m | BIT_DOWN) : (m & ~BIT_DOWN);
          end
          pad_mask[hit] = m;
        end
      end
      OP_READ: begin
        if (int'(ev.pad_number) < pad_count) r.pad_buttons = pad_mask[ev.pad_number];
      end
      default: ;
    endcase
    r.pads_connected = 4'(pad_count);
    return r;
  endfunction

  function automatic gst_event_t ev_of(input logic [2:0] op, input logic [31:0] id,
                                       input logic [7:0] code, input logic [7:0] axis,
                                       input logic signed [15:0] value,
                                       input logic [2:0] pad);
    gst_event_t ev;
    ev.operation   = op;
    ev.device_id   = id;
    ev.button_code = code;
    ev.axis_number = axis;
    ev.axis_value  = value;
    ev.pad_number  = pad;
    return ev;
  endfunction

  // Mostly events on connected ids with meaningful codes, the rest noise
  function automatic gst_event_t random_event();
    gst_event_t  ev;
    int unsigned pick;
    int          t;
    ev = ev_of(3'($urandom), $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
               3'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 14) ev.operation = OP_ADD;
    else if (pick < 28) ev.operation = OP_REMOVE;
    else if (pick < 50) ev.operation = OP_BTN_DOWN;
    else if (pick < 64) ev.operation = OP_BTN_UP;
    else if (pick < 84) ev.operation = OP_AXIS;
    else if (pick < 96) ev.operation = OP_READ;
    else ev.operation = ($urandom_range(0, 1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
    if (pad_count > 0) begin
      if (ev.operation != OP_ADD && $urandom_range(0, 9) < 8)
        ev.device_id = pad_id[$urandom_range(0, pad_count - 1)];
      else if (ev.operation == OP_ADD && $urandom_range(0, 9) < 2)
        ev.device_id = pad_id[$urandom_range(0, pad_count - 1)];
    end
    if ($urandom_range(0, 9) < 8) ev.button_code = 8'($urandom_range(0, 14));
    if ($urandom_range(0, 9) < 8)
      ev.axis_number = ($urandom_range(0, 1) != 0) ? AXIS_VERTICAL : AXIS_HORIZONTAL;
    // aim at the threshold edges half the time
    t = int'(threshold_now);
    case ($urandom_range(0, 7))
      0: ev.axis_value = 16'(t);
      1: ev.axis_value = 16'(t + 1);
      2: ev.axis_value = 16'(-t);
      3: ev.axis_value = 16'(-t - 1);
      default: ;
    endcase
    return ev;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Offer one event word, wait for acceptance, record the owed result
  task automatic send_event(input gst_event_t ev);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= ev.operation;
    in_device_id   <= ev.device_id;
    in_button_code <= ev.button_code;
    in_axis_number <= ev.axis_number;
    in_axis_value  <= ev.axis_value;
    in_pad_number  <= ev.pad_number;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(apply_event_to_table(ev));
    events_sent++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [14:0] value);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_now = value;
  endtask

  task automatic test_table_setup();
    send_event(ev_of(OP_ADD, ID_FIRST, '0, '0, '0, '0));
    send_event(ev_of(OP_ADD, ID_SECOND, '0, '0, '0, '0));
    // duplicate id takes a new slot; events go to the lower one
    send_event(ev_of(OP_ADD, ID_FIRST, '0, '0, '0, '0));
  endtask

  task automatic test_button_events();
    send_event(ev_of(OP_BTN_DOWN, ID_FIRST, BTN_GUIDE, '0, '0, '0));
    send_event(ev_of(OP_BTN_DOWN, ID_FIRST, BTN_DPAD_RIGHT, '0, '0, '0));
    send_event(ev_of(OP_BTN_DOWN, ID_FIRST, CODE_UNKNOWN, '0, '0, '0));
    send_event(ev_of(OP_BTN_DOWN, ID_FIRST, BTN_RIGHT_SHOULDER, '0, '0, '0));
    send_event(ev_of(OP_BTN_UP, ID_FIRST, BTN_DPAD_RIGHT, '0, '0, '0));
  endtask

  task automatic test_axis_events();
    send_event(ev_of(OP_AXIS, ID_FIRST, '0, AXIS_HORIZONTAL, 16'sh8000, '0));
    send_event(ev_of(OP_AXIS, ID_FIRST, '0, AXIS_VERTICAL, 16'sh7FFF, '0));
    send_event(ev_of(OP_AXIS, ID_FIRST, '0, AXIS_UNUSED, 16'sh8000, '0));
    // exactly at the threshold sets nothing, one above sets right
    send_event(ev_of(OP_AXIS, ID_SECOND, '0, AXIS_HORIZONTAL,
                     16'(AXIS_THRESHOLD_RESET), '0));
    send_event(ev_of(OP_AXIS, ID_SECOND, '0, AXIS_HORIZONTAL,
                     16'(AXIS_THRESHOLD_RESET + 15'd1), '0));
  endtask

  task automatic test_reads_and_unknown_id();
    send_event(ev_of(OP_READ, '0, '0, '0, '0, 3'd0));
    send_event(ev_of(OP_READ, '0, '0, '0, '0, 3'd2));
    send_event(ev_of(OP_READ, '0, '0, '0, '0, 3'd7));
    send_event(ev_of(OP_BTN_DOWN, ID_STRANGER, BTN_A, '0, '0, '0));
  endtask

  task automatic test_remove_shift();
    send_event(ev_of(OP_REMOVE, ID_FIRST, '0, '0, '0, '0));
    send_event(ev_of(OP_READ, '0, '0, '0, '0, 3'd0));
    send_event(ev_of(OP_READ, '0, '0, '0, '0, 3'd1));
    send_event(ev_of(OP_REMOVE, ID_STRANGER, '0, '0, '0, '0));
  endtask

  task automatic test_undefined_ops();
    send_event(ev_of(OP_UNDEF_LO, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                     3'($urandom)));
    send_event(ev_of(OP_UNDEF_HI, $urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                     3'($urandom)));
  endtask

  task automatic test_table_full();
    while (pad_count < PADS) send_event(ev_of(OP_ADD, $urandom, '0, '0, '0, '0));
    send_event(ev_of(OP_ADD, ID_STRANGER, '0, '0, '0, '0));
  endtask

  // Hold the result side off long enough that the block stalls its input
  task automatic test_output_backpressure();
    // drop valid so the last word is not offered again while waiting
    in_valid <= 1'b0;
    hold_request = 1'b1;
    while (!holding) @(posedge clk);
    steady = 1'b1;
    repeat (16) send_event(random_event());
    steady = 1'b0;
  endtask

  task automatic run_random_phase(input logic [14:0] threshold, input int count,
                                  input bit calm);
    write_threshold(threshold);
    steady = calm;
    repeat (count) send_event(random_event());
    steady = 1'b0;
  endtask

  task automatic test_threshold_sweep();
    run_random_phase(15'd0, 150, 1'b0);
    run_random_phase(15'h7FFF, 150, 1'b0);
    run_random_phase(15'($urandom_range(1, 32766)), 60, 1'b1);
    run_random_phase(15'($urandom_range(1, 32766)), 240, 1'b0);
  endtask

  // Result side: random stalls, calm stretches, and one long hold on request
  initial begin : result_stall
    int unsigned len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holding = 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 30) begin
        len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest owed one
  always @(posedge clk) begin : result_check
    gst_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_status.size() == 0) begin
        $error("result word with nothing owed: pad_buttons %h pads_connected %0d flag %b",
               out_pad_buttons, out_pads_connected, out_id_not_found);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (out_pad_buttons !== want.pad_buttons) begin
          $error("pad_buttons: expected %h, got %h", want.pad_buttons, out_pad_buttons);
          mismatches++;
        end
        if (out_pads_connected !== want.pads_connected) begin
          $error("pads_connected: expected %0d, got %0d", want.pads_connected,
                 out_pads_connected);
          mismatches++;
        end
        if (out_id_not_found !== want.id_not_found) begin
          $error("id_not_found: expected %b, got %b", want.id_not_found, out_id_not_found);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_operation   <= '0;
    in_device_id   <= '0;
    in_button_code <= '0;
    in_axis_number <= '0;
    in_axis_value  <= '0;
    in_pad_number  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_setup();
    test_button_events();
    test_axis_events();
    test_reads_and_unknown_id();
    test_remove_shift();
    test_undefined_ops();
    test_table_full();
    test_output_backpressure();
    test_threshold_sweep();

    // drain and give the pipeline time to show any stray word
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d events sent, %0d results checked, %0d mismatches",
             events_sent, results_checked, mismatches);
    $display("tb: covered add/refuse/remove-shift, buttons, axes at thresholds, stalls");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
